// File: rtl/lion_pkg.sv
`timescale 1ns / 1ps

package lion_pkg;

   localparam int COEF_W    = 17;
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 50;
   localparam int ACC_W     = PROD_W - FRAC_W;
   localparam int STAGES    = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(1 << FRAC_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BETA_ONE      = 3'd0,
      CSR_BETA_TWO      = 3'd1,
      CSR_LEARNING_RATE = 3'd2,
      CSR_DECAY         = 3'd3,
      CSR_FIRST_STEP    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] beta_one;
      logic [COEF_W-1:0] beta_one_c;
      logic [COEF_W-1:0] beta_two;
      logic [COEF_W-1:0] beta_two_c;
      logic [COEF_W-1:0] learning_rate;
      logic [COEF_W-1:0] decay;
      logic              decay_en;
      logic              first_step;
   } lion_coef_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } lion_stage_ctl_type;

endpackage

// File: rtl/lion_csr.sv
`timescale 1ns / 1ps

module lion_csr import lion_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_write_data,
   output lion_coef_type        coef
);

   localparam logic [COEF_W-1:0] BETA_ONE_RST = COEF_W'(58982);
   localparam logic [COEF_W-1:0] BETA_TWO_RST = COEF_W'(65209);
   localparam logic [COEF_W-1:0] LR_RST       = COEF_W'(7);

   logic [COEF_W-1:0] beta_one_ff, beta_one_in;
   logic [COEF_W-1:0] beta_two_ff, beta_two_in;
   logic [COEF_W-1:0] lr_ff, lr_in;
   logic [COEF_W-1:0] decay_ff, decay_in;
   logic              first_step_ff, first_step_in;
   logic [COEF_W-1:0] wdata_clamped;

   // limit to one
   assign wdata_clamped = (csr_write_data > Q_ONE) ? Q_ONE : csr_write_data;

   always_comb begin
      beta_one_in   = beta_one_ff;
      beta_two_in   = beta_two_ff;
      lr_in         = lr_ff;
      decay_in      = decay_ff;
      first_step_in = first_step_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BETA_ONE:      beta_one_in   = wdata_clamped;
            CSR_BETA_TWO:      beta_two_in   = wdata_clamped;
            CSR_LEARNING_RATE: lr_in         = wdata_clamped;
            CSR_DECAY:         decay_in      = wdata_clamped;
            CSR_FIRST_STEP:    first_step_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_one_ff   <= BETA_ONE_RST;
         beta_two_ff   <= BETA_TWO_RST;
         lr_ff         <= LR_RST;
         decay_ff      <= '0;
         first_step_ff <= 1'b1;
      end else begin
         beta_one_ff   <= beta_one_in;
         beta_two_ff   <= beta_two_in;
         lr_ff         <= lr_in;
         decay_ff      <= decay_in;
         first_step_ff <= first_step_in;
      end
   end

   assign coef.beta_one      = beta_one_ff;
   assign coef.beta_one_c    = Q_ONE - beta_one_ff;
   assign coef.beta_two      = beta_two_ff;
   assign coef.beta_two_c    = Q_ONE - beta_two_ff;
   assign coef.learning_rate = lr_ff;
   assign coef.decay         = decay_ff;
   assign coef.decay_en      = |decay_ff;
   assign coef.first_step    = first_step_ff;

endmodule

// File: rtl/lion_flow.sv
`timescale 1ns / 1ps

module lion_flow import lion_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lion_stage_ctl_type ctl
);

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

endmodule

// File: rtl/lion_datapath.sv
`timescale 1ns / 1ps

module lion_datapath import lion_pkg::*; (
   input  logic                     clock,
   input  lion_stage_ctl_type       ctl,
   input  lion_coef_type            coef,
   input  logic signed [DATA_W-1:0] req_gradient,
   input  logic signed [DATA_W-1:0] req_moment_in,
   input  logic signed [DATA_W-1:0] req_weight_in,
   input  logic                     req_last_element,
   output logic signed [DATA_W-1:0] rsp_moment_out,
   output logic signed [DATA_W-1:0] rsp_weight_out,
   output logic                     rsp_last_out
);

   localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1 << (FRAC_W - 1));
   localparam logic [2*COEF_W-1:0]      HALF_U = (2*COEF_W)'(1 << (FRAC_W - 1));

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // stage 1: momentum products, decay product
   logic signed [PROD_W-1:0]   s1_mb_ff, s1_mb_in, s1_gb_ff, s1_gb_in;
   logic signed [PROD_W-1:0]   s1_mb_prod;
   logic [2*COEF_W-1:0]        s1_lw_ff, s1_lw_in;
   logic signed [DATA_W-1:0]   s1_g_ff, s1_p_ff;
   logic                       s1_last_ff;

   assign s1_mb_prod = $signed({1'b0, coef.beta_one}) * req_moment_in;
   assign s1_mb_in   = coef.first_step ? '0 : s1_mb_prod;
   assign s1_gb_in   = $signed({1'b0, coef.beta_one_c}) * req_gradient;
   assign s1_lw_in   = coef.learning_rate * coef.decay;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_mb_ff   <= s1_mb_in;
         s1_gb_ff   <= s1_gb_in;
         s1_lw_ff   <= s1_lw_in;
         s1_g_ff    <= req_gradient;
         s1_p_ff    <= req_weight_in;
         s1_last_ff <= req_last_element;
      end
   end

   // stage 2: round and saturate momentum, decay factor
   logic signed [PROD_W-1:0]   s2_macc;
   logic [2*COEF_W-1:0]        s2_lw_rnd;
   logic signed [DATA_W-1:0]   s2_mnew_ff, s2_mnew_in, s2_g_ff, s2_p_ff;
   logic [COEF_W-1:0]          s2_f_ff, s2_f_in;
   logic                       s2_last_ff;

   assign s2_macc    = s1_mb_ff + s1_gb_ff + HALF_P;
   assign s2_mnew_in = sat32(s2_macc[PROD_W-1:FRAC_W]);
   assign s2_lw_rnd  = s1_lw_ff + HALF_U;
   assign s2_f_in    = Q_ONE - s2_lw_rnd[FRAC_W+COEF_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_mnew_ff <= s2_mnew_in;
         s2_f_ff    <= s2_f_in;
         s2_g_ff    <= s1_g_ff;
         s2_p_ff    <= s1_p_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 3: decayed weight product, direction products
   logic signed [PROD_W-1:0]   s3_pf_ff, s3_pf_in, s3_d1_ff, s3_d1_in, s3_d2_ff, s3_d2_in;
   logic signed [DATA_W-1:0]   s3_mnew_ff, s3_p_ff;
   logic                       s3_last_ff;

   assign s3_pf_in = s2_p_ff * $signed({1'b0, s2_f_ff});
   assign s3_d1_in = $signed({1'b0, coef.beta_two}) * s2_mnew_ff;
   assign s3_d2_in = $signed({1'b0, coef.beta_two_c}) * s2_g_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_pf_ff   <= s3_pf_in;
         s3_d1_ff   <= s3_d1_in;
         s3_d2_ff   <= s3_d2_in;
         s3_mnew_ff <= s2_mnew_ff;
         s3_p_ff    <= s2_p_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // stage 4: round decayed weight, direction sign
   logic signed [PROD_W-1:0]   s4_pf_rnd, s4_dir;
   logic signed [ACC_W-1:0]    s4_pdec_ff, s4_pdec_in;
   logic                       s4_pos_ff, s4_pos_in, s4_neg_ff, s4_neg_in;
   logic signed [DATA_W-1:0]   s4_mnew_ff;
   logic                       s4_last_ff;

   assign s4_pf_rnd  = s3_pf_ff + HALF_P;
   assign s4_pdec_in = coef.decay_en ? s4_pf_rnd[PROD_W-1:FRAC_W]
                                     : {{(ACC_W-DATA_W){s3_p_ff[DATA_W-1]}}, s3_p_ff};
   assign s4_dir     = s3_d1_ff + s3_d2_ff;
   assign s4_neg_in  = s4_dir[PROD_W-1];
   assign s4_pos_in  = !s4_dir[PROD_W-1] && (|s4_dir);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_pdec_ff <= s4_pdec_in;
         s4_pos_ff  <= s4_pos_in;
         s4_neg_ff  <= s4_neg_in;
         s4_mnew_ff <= s3_mnew_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // stage 5: signed step, saturate, output register
   logic signed [ACC_W-1:0]    s5_lr, s5_wsum;
   logic signed [DATA_W-1:0]   s5_w_ff, s5_w_in, s5_mnew_ff;
   logic                       s5_last_ff;

   assign s5_lr = $signed({{(ACC_W-COEF_W){1'b0}}, coef.learning_rate});

   always_comb begin
      priority if (s4_pos_ff) begin
         s5_wsum = s4_pdec_ff - s5_lr;
      end else if (s4_neg_ff) begin
         s5_wsum = s4_pdec_ff + s5_lr;
      end else begin
         s5_wsum = s4_pdec_ff;
      end
   end

   assign s5_w_in = sat32(s5_wsum);

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_w_ff    <= s5_w_in;
         s5_mnew_ff <= s4_mnew_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   assign rsp_moment_out = s5_mnew_ff;
   assign rsp_weight_out = s5_w_ff;
   assign rsp_last_out   = s5_last_ff;

endmodule

// File: rtl/lion_optimizer_step_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   gradient, moment_in, weight_in, last_element
// rsp      out        rsp_valid/rsp_ready   moment_out, weight_out, last_out
// csr      in         csr_write_enable      csr_index, csr_write_data
//
// One transaction per cycle while rsp_ready is high; rsp_valid marks the last stage.
// The five register stages are set by the two chained products (decay factor, then
// decayed weight; momentum, then direction), each followed by a register.
// Synchronous reset empties the pipeline and loads the register reset values.
// Stalls on rsp back up stage by stage; empty stages still advance.

module lion_optimizer_step_core import lion_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_gradient,
   input  logic signed [DATA_W-1:0] req_moment_in,
   input  logic signed [DATA_W-1:0] req_weight_in,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_moment_out,
   output logic signed [DATA_W-1:0] rsp_weight_out,
   output logic                     rsp_last_out,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_write_data
);

   lion_coef_type      coef;
   lion_stage_ctl_type ctl;

   lion_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .coef             (coef)
   );

   lion_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   lion_datapath u_datapath (
      .clock            (clock),
      .ctl              (ctl),
      .coef             (coef),
      .req_gradient     (req_gradient),
      .req_moment_in    (req_moment_in),
      .req_weight_in    (req_weight_in),
      .req_last_element (req_last_element),
      .rsp_moment_out   (rsp_moment_out),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_last_out     (rsp_last_out)
   );

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&ctl.valid) && !rsp_ready))
      else $error("input stalled with an empty stage");

   assert property (@(posedge clock) reset |=> (!rsp_valid && (ctl.valid == '0)))
      else $error("pipeline not empty after reset");
`endif

endmodule
